// File: rtl/assert_macros.svh
// Assertion macros shared by the servo pulse generator modules.
// Depends on nothing; the using module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define SPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds while reset is high.
`define SPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/spg_pkg.sv
// Types and constants of the servo pulse generator.
// Used by every module of the block; depends on nothing.
package spg_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_FRAME_TICKS = 2'd1;
  localparam logic [1:0] REG_MIN_TICKS   = 2'd2;
  localparam logic [1:0] REG_SPAN_TICKS  = 2'd3;

  localparam logic        RESET_ENABLE      = 1'b0;
  localparam logic [15:0] RESET_FRAME_TICKS = 16'd2500;
  localparam logic [7:0]  RESET_MIN_TICKS   = 8'd100;
  localparam logic [7:0]  RESET_SPAN_TICKS  = 8'd170;

  localparam logic [7:0] POS_FULL_SCALE = 8'd255;
  localparam int         DIV_STEPS      = 16;

  typedef struct packed {
    logic        enable;
    logic [15:0] frame_ticks;
    logic [7:0]  min_ticks;
    logic [7:0]  span_ticks;
  } cfg_t;

  typedef struct packed {
    logic pin;
    logic running;
  } tmr_status_t;

  typedef struct packed {
    logic       pin_level;
    logic       pulse_running;
    logic [7:0] position_readback;
  } res_t;

endpackage

// File: rtl/spg_if.sv
// Handshake interfaces of the servo pulse generator: requests, results and
// register writes. Depends on nothing.
interface spg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] position;
  modport source (output valid, opcode, position, input ready);
  modport sink (input valid, opcode, position, output ready);
endinterface

interface spg_res_if;
  logic       valid;
  logic       ready;
  logic       pin_level;
  logic       pulse_running;
  logic [7:0] position_readback;
  modport source (output valid, pin_level, pulse_running, position_readback, input ready);
  modport sink (input valid, pin_level, pulse_running, position_readback, output ready);
endinterface

interface spg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/spg_divider.sv
// Shared restoring divider of a 16-bit dividend by an 8-bit divisor, one quotient bit per cycle.
// Depends on spg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spg_divider
  import spg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic [15:0] quotient
);

  logic [3:0]  step;
  logic [7:0]  rem;
  logic [7:0]  dsr;
  logic [15:0] quo;
  logic [8:0]  shifted;
  logic [8:0]  trial;
  logic        fits;

  assign shifted = {rem, quo[15]};
  assign trial   = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 4'd1;
      if (step == 4'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial[7:0] : shifted[7:0];
      quo <= {quo[14:0], fits};
    end
  end

  assign quotient = quo;

  `SPG_ASSERT(a_start_idle, start |-> !busy, "divider started while busy")
  `SPG_ASSERT(a_div_length, start |-> ##17 !busy, "divide did not finish in time")

endmodule

// File: rtl/spg_timer.sv
// Frame counter and two-phase pulse timer that drive the servo pin.
// Depends on spg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spg_timer
  import spg_pkg::*;
#(
  parameter int FRAME_COUNT_WIDTH = 16,
  parameter int PULSE_COUNT_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  cfg_t        cfg,
  input  logic [7:0]  scaled_position,
  output tmr_status_t status_next
);

  localparam int CMP_W = (FRAME_COUNT_WIDTH > 16) ? FRAME_COUNT_WIDTH : 16;

  logic [FRAME_COUNT_WIDTH-1:0] frame_count, frame_count_next;
  logic [PULSE_COUNT_WIDTH-1:0] pulse_count, pulse_count_next;
  logic [7:0]                   pulse_compare, pulse_compare_next;
  logic                         pulse_phase, pulse_phase_next;
  logic                         running, running_next;
  logic                         pin, pin_next;

  always_comb begin
    frame_count_next   = frame_count;
    pulse_count_next   = pulse_count;
    pulse_compare_next = pulse_compare;
    pulse_phase_next   = pulse_phase;
    running_next       = running;
    pin_next           = pin;
    if (step) begin
      if (running) begin
        if (pulse_count == PULSE_COUNT_WIDTH'(pulse_compare)) begin
          pulse_count_next = '0;
          if (!pulse_phase) begin
            pulse_phase_next   = 1'b1;
            pulse_compare_next = scaled_position;
          end else begin
            pin_next           = 1'b0;
            pulse_phase_next   = 1'b0;
            running_next       = 1'b0;
            pulse_compare_next = cfg.min_ticks;
          end
        end else begin
          pulse_count_next = pulse_count + 1'b1;
        end
      end
      frame_count_next = frame_count + 1'b1;
      if (CMP_W'(frame_count_next) >= CMP_W'(cfg.frame_ticks)) begin
        frame_count_next = '0;
        if (cfg.enable) begin
          pin_next = 1'b1;
          if (!running_next) begin
            running_next       = 1'b1;
            pulse_count_next   = '0;
            pulse_phase_next   = 1'b0;
            pulse_compare_next = cfg.min_ticks;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      pulse_count   <= '0;
      pulse_compare <= RESET_MIN_TICKS;
      pulse_phase   <= 1'b0;
      running       <= 1'b0;
      pin           <= 1'b0;
    end else begin
      frame_count   <= frame_count_next;
      pulse_count   <= pulse_count_next;
      pulse_compare <= pulse_compare_next;
      pulse_phase   <= pulse_phase_next;
      running       <= running_next;
      pin           <= pin_next;
    end
  end

  assign status_next.pin     = pin_next;
  assign status_next.running = running_next;

  `SPG_ASSERT_ALWAYS(a_running_pin, running |-> pin, "pulse timer running with pin low")

endmodule

// File: rtl/spg_result_queue.sv
// Two-entry result queue: an output register with a skid register behind it.
// Depends on spg_pkg, spg_if and assert_macros.svh.
`include "assert_macros.svh"
module spg_result_queue
  import spg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  res_t             push_data,
  output logic             full,
  spg_res_if.source        res
);

  res_t head, skid;
  logic head_valid, skid_valid;
  logic pop;

  assign pop  = head_valid && res.ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (head_valid) begin
        skid <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

  assign res.valid             = head_valid;
  assign res.pin_level         = head.pin_level;
  assign res.pulse_running     = head.pulse_running;
  assign res.position_readback = head.position_readback;

  `SPG_ASSERT_ALWAYS(a_skid_order, skid_valid |-> head_valid, "skid entry without head entry")
  `SPG_ASSERT(a_no_overflow, full |-> !push, "push into full result queue")

endmodule

// File: rtl/servo_pulse_generator_top.sv
// Channel  | Direction | Carries
// cmd      | sink      | opcode, position
// res      | source    | pin_level, pulse_running, position_readback
// cfg      | sink      | index, data (register write)
//
// A tick, set or no-op request is pushed in the cycle it is accepted, as is a read with a zero span.
// A read goes from the accept through S_MUL, which loads the divider, then S_DIV, which holds
// for the divide steps until the divider is seen to finish, and S_PUSH, which pushes the result.
// The divider is bit-serial; a full queue holds a read in the push.
// Reset is synchronous; there is no clearing pass.
// Results wait in a two-entry queue, so a request is taken while one waits.
`include "assert_macros.svh"
module servo_pulse_generator_top
  import spg_pkg::*;
#(
  parameter int FRAME_COUNT_WIDTH = 16,
  parameter int PULSE_COUNT_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  spg_in_if.sink    cmd,
  spg_res_if.source res,
  spg_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t      state, state_next;
  cfg_t        regs;
  logic [7:0]  scaled_position;
  logic        cmd_fire, direct, q_full, push, div_start, div_busy, finish;
  logic [15:0] product, quotient, set_product, set_sum;
  logic [7:0]  quot_sat;
  tmr_status_t tmr_next;
  res_t        push_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable      <= RESET_ENABLE;
      regs.frame_ticks <= RESET_FRAME_TICKS;
      regs.min_ticks   <= RESET_MIN_TICKS;
      regs.span_ticks  <= RESET_SPAN_TICKS;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE:      regs.enable      <= cfg.data[0];
        REG_FRAME_TICKS: regs.frame_ticks <= cfg.data;
        REG_MIN_TICKS:   regs.min_ticks   <= cfg.data[7:0];
        REG_SPAN_TICKS:  regs.span_ticks  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE) && !q_full;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign direct    = (cmd.opcode inside {OP_TICK, OP_SET, OP_NOP}) ||
                     ((cmd.opcode == OP_READ) && (regs.span_ticks == 8'd0));
  assign finish    = (state == S_PUSH) && !q_full;
  assign push      = (cmd_fire && direct) || finish;
  assign div_start = (state == S_MUL);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd_fire && !direct) state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (!div_busy) state_next = S_PUSH;
      S_PUSH: if (!q_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      scaled_position <= '0;
    end else begin
      state <= state_next;
      if (cmd_fire && (cmd.opcode == OP_SET)) begin
        scaled_position <= set_sum[15:8];
      end
    end
  end

  // Set scales span * position / 255 through a multiplication by the reciprocal of 255.
  // Read rebuilds scaled * 255 / span on the shared divider.
  assign set_product = 16'(regs.span_ticks) * 16'(cmd.position);
  assign set_sum     = set_product + (set_product >> 8) + 16'd1;
  assign product     = 16'(scaled_position) * 16'(POS_FULL_SCALE);
  assign quot_sat    = (quotient > 16'(POS_FULL_SCALE)) ? POS_FULL_SCALE : quotient[7:0];

  spg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (regs.span_ticks),
    .busy     (div_busy),
    .quotient (quotient)
  );

  spg_timer #(
    .FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH),
    .PULSE_COUNT_WIDTH (PULSE_COUNT_WIDTH)
  ) u_timer (
    .clk             (clk),
    .rst             (rst),
    .step            (cmd_fire && (cmd.opcode == OP_TICK)),
    .cfg             (regs),
    .scaled_position (scaled_position),
    .status_next     (tmr_next)
  );

  assign push_data.pin_level         = tmr_next.pin;
  assign push_data.pulse_running     = tmr_next.running;
  assign push_data.position_readback = finish ? quot_sat : 8'd0;

  spg_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .res       (res)
  );

  `SPG_ASSERT(a_mul_to_div, div_start |=> (state == S_DIV) && div_busy, "divide not under way")
  `SPG_ASSERT(a_push_idle, finish |=> state == S_IDLE, "sequencer did not return to idle")

endmodule

// File: tb/tb_servo_pulse_generator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of servo_pulse_generator_top, with a cycle-true predictor of the pulse
// timer, frame counter and position scaling. It depends on spg_pkg, the three handshake
// interfaces and the top module; it compares every result with the predictor's output.
module tb_servo_pulse_generator_top;
  import spg_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 115;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spg_in_if cmd_if();
  spg_res_if res_if();
  spg_cfg_if cfg_if();

  servo_pulse_generator_top dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cfg_t model_cfg;
  logic [15:0] frame_count;
  logic [7:0] pulse_count;
  logic [7:0] pulse_compare;
  logic [7:0] scaled_pos;
  logic pulse_phase;
  logic timer_on;
  logic pin;

  res_t expected_results[$];
  int mismatch_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int writes_done = 0;
  int pulses_started = 0;
  int frames_in_pulse = 0;
  int reads_sent = 0;
  int cycle_count = 0;

  int burst_left = 0;
  bit steady_sender = 1'b0;
  int hold_off_left = 0;
  int pattern_left = 0;
  int stall_pct = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic res_t predict_servo_output(input logic [1:0] op, input logic [7:0] pos);
    res_t out;
    int quotient;
    out.position_readback = '0;
    case (op)
      OP_TICK: begin
        if (timer_on) begin
          if (pulse_count == pulse_compare) begin
            pulse_count = '0;
            if (!pulse_phase) begin
              pulse_phase = 1'b1;
              pulse_compare = scaled_pos;
            end else begin
              pin = 1'b0;
              pulse_phase = 1'b0;
              timer_on = 1'b0;
              pulse_compare = model_cfg.min_ticks;
            end
          end else begin
            pulse_count = pulse_count + 8'd1;
          end
        end
        frame_count = frame_count + 16'd1;
        if (frame_count >= model_cfg.frame_ticks) begin
          frame_count = '0;
          if (model_cfg.enable) begin
            pin = 1'b1;
            if (timer_on) begin
              frames_in_pulse++;
            end else begin
              pulses_started++;
              timer_on = 1'b1;
              pulse_count = '0;
              pulse_phase = 1'b0;
              pulse_compare = model_cfg.min_ticks;
            end
          end
        end
      end
      OP_SET: begin
        quotient = (int'(model_cfg.span_ticks) * int'(pos)) / int'(POS_FULL_SCALE);
        scaled_pos = (quotient > 255) ? 8'd255 : quotient[7:0];
      end
      OP_READ: begin
        if (model_cfg.span_ticks != '0) begin
          quotient = (int'(scaled_pos) * int'(POS_FULL_SCALE)) / int'(model_cfg.span_ticks);
          out.position_readback = (quotient > 255) ? 8'd255 : quotient[7:0];
        end
      end
      default: begin
      end
    endcase
    out.pin_level = pin;
    out.pulse_running = timer_on;
    return out;
  endfunction

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", int'(got), 0);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (got.pin_level !== want.pin_level)
        report_mismatch("pin_level", int'(got.pin_level), int'(want.pin_level));
      if (got.pulse_running !== want.pulse_running)
        report_mismatch("pulse_running", int'(got.pulse_running), int'(want.pulse_running));
      if (got.position_readback !== want.position_readback)
        report_mismatch("position_readback", int'(got.position_readback),
                        int'(want.position_readback));
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && res_if.valid && res_if.ready) begin
      check_result('{res_if.pin_level, res_if.pulse_running, res_if.position_readback});
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        res_if.ready <= 1'b0;
        hold_off_left--;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        pattern_left--;
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("servo_pulse_generator_top regression: fail");
    $finish;
  end

  task automatic send_request(input logic [1:0] op, input logic [7:0] pos);
    int gap;
    @(negedge clk);
    cmd_if.valid <= 1'b1;
    cmd_if.opcode <= op;
    cmd_if.position <= pos;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    expected_results.push_back(predict_servo_output(op, pos));
    requests_sent++;
    if (op == OP_READ) reads_sent++;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        gap = $urandom_range(1, 10);
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_random_request();
    int pick;
    logic [1:0] op;
    logic [7:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 72) op = OP_TICK;
    else if (pick < 82) op = OP_SET;
    else if (pick < 92) op = OP_READ;
    else op = OP_NOP;
    pick = $urandom_range(0, 99);
    if (pick < 10) pos = 8'd0;
    else if (pick < 20) pos = 8'd255;
    else pos = 8'($urandom_range(0, 255));
    send_request(op, pos);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_ENABLE: model_cfg.enable = value[0];
      REG_FRAME_TICKS: model_cfg.frame_ticks = value;
      REG_MIN_TICKS: model_cfg.min_ticks = value[7:0];
      REG_SPAN_TICKS: model_cfg.span_ticks = value[7:0];
      default: begin
      end
    endcase
    writes_done++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_all_registers(input logic en, input logic [15:0] frame,
                                   input logic [7:0] min_part, input logic [7:0] span);
    write_register(REG_ENABLE, {15'd0, en});
    write_register(REG_FRAME_TICKS, frame);
    write_register(REG_MIN_TICKS, {8'd0, min_part});
    write_register(REG_SPAN_TICKS, {8'd0, span});
  endtask

  task automatic test_idle_after_reset();
    send_request(OP_READ, 8'd0);
    send_request(OP_TICK, 8'd255);
    send_request(OP_TICK, 8'd0);
    send_request(OP_NOP, 8'd170);
    drain_requests();
  endtask

  task automatic test_position_conversion();
    send_request(OP_SET, 8'd255);
    send_request(OP_READ, 8'd0);
    send_request(OP_SET, 8'd128);
    send_request(OP_READ, 8'd0);
    drain_requests();
    write_register(REG_SPAN_TICKS, 16'd255);
    send_request(OP_SET, 8'd255);
    drain_requests();
    // A narrower span makes the stored position's read-back saturate at full scale.
    write_register(REG_SPAN_TICKS, 16'd1);
    send_request(OP_READ, 8'd0);
    drain_requests();
    write_register(REG_SPAN_TICKS, 16'd0);
    send_request(OP_READ, 8'd0);
    send_request(OP_SET, 8'd200);
    drain_requests();
  endtask

  task automatic test_pulse_timing();
    set_all_registers(1'b0, 16'd2, 8'd0, 8'd255);
    send_request(OP_SET, 8'd1);
    repeat (3) send_request(OP_TICK, 8'd0);
    drain_requests();
    write_register(REG_ENABLE, 16'd1);
    repeat (4) send_request(OP_TICK, 8'd0);
    drain_requests();
    // A new minimum part only applies from the next pulse onwards.
    write_register(REG_MIN_TICKS, 16'd3);
    write_register(REG_FRAME_TICKS, 16'd0);
    repeat (8) send_request(OP_TICK, 8'd0);
    drain_requests();
  endtask

  task automatic test_random_settings();
    logic en;
    logic [15:0] frame;
    logic [7:0] min_part;
    logic [7:0] span;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        en = 1'b1; frame = 16'd1; min_part = 8'd255; span = 8'd255;
      end else if (phase == 1) begin
        en = 1'b0; frame = 16'd65535; min_part = 8'd0; span = 8'd0;
      end else begin
        en = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 5))
          0: frame = 16'd0;
          1: frame = 16'd1;
          2: frame = 16'($urandom_range(2, 12));
          5: frame = 16'd65535;
          default: frame = 16'($urandom_range(13, 400));
        endcase
        case ($urandom_range(0, 3))
          0: min_part = 8'd0;
          1: min_part = 8'd255;
          default: min_part = 8'($urandom_range(0, 30));
        endcase
        case ($urandom_range(0, 3))
          0: span = 8'd0;
          1: span = 8'd255;
          default: span = 8'($urandom_range(0, 255));
        endcase
      end
      set_all_registers(en, frame, min_part, span);
      repeat (ITEMS_PER_PHASE) send_random_request();
      drain_requests();
    end
  endtask

  task automatic test_receiver_holdoff();
    set_all_registers(1'b1, 16'd5, 8'd2, 8'd40);
    @(posedge clk);
    hold_off_left = 300;
    steady_sender = 1'b1;
    repeat (60) send_random_request();
    steady_sender = 1'b0;
    drain_requests();
  endtask

  task automatic test_sender_pause();
    repeat (40) send_random_request();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) send_random_request();
    drain_requests();
  endtask

  initial begin
    model_cfg = '{RESET_ENABLE, RESET_FRAME_TICKS, RESET_MIN_TICKS, RESET_SPAN_TICKS};
    frame_count = '0;
    pulse_count = '0;
    pulse_compare = RESET_MIN_TICKS;
    scaled_pos = '0;
    pulse_phase = 1'b0;
    timer_on = 1'b0;
    pin = 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.opcode <= OP_TICK;
    cmd_if.position <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_ENABLE;
    cfg_if.data <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_after_reset();
    test_position_conversion();
    test_pulse_timing();
    test_random_settings();
    test_receiver_holdoff();
    test_sender_pause();

    while (expected_results.size() != 0) begin
      report_mismatch("result never delivered", 0, 1);
      void'(expected_results.pop_front());
    end
    $display("Sent %0d requests (%0d reads) over %0d register writes; %0d results checked.",
             requests_sent, reads_sent, writes_done, results_checked);
    $display("Pulses started: %0d; frames that arrived during a pulse: %0d.",
             pulses_started, frames_in_pulse);
    if (mismatch_count == 0) begin
      $display("servo_pulse_generator_top regression: pass");
    end else begin
      $display("servo_pulse_generator_top regression: fail");
    end
    $finish;
  end

endmodule
